@@ design/itar_pkg.sv @@
// Shared types, constants and helpers for the integer-to-ASCII radix converter.
// No dependencies.

package itar_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int RADIX_WIDTH        = 6;
   localparam int CHAR_WIDTH         = 7;

   localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_WIDTH-1:0] DEC_RADIX   = 6'd10;
   localparam logic [RADIX_WIDTH-1:0] LAST_PLAIN_DIGIT = 6'd9;

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO   = 7'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE   = 7'h39;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOW_A  = 7'h61;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOW_Z  = 7'h7a;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS  = 7'h2d;
   localparam logic [CHAR_WIDTH-1:0] LETTER_BIAS = CHAR_LOW_A - 7'd10;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                   done;
      logic                   quo_zero;
      logic [RADIX_WIDTH-1:0] remainder;
   } div_status_type;

   function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [RADIX_WIDTH-1:0] d);
      logic [CHAR_WIDTH-1:0] d_ext;
      d_ext = {1'b0, d};
      if (d > LAST_PLAIN_DIGIT) begin
         return d_ext + LETTER_BIAS;
      end
      return d_ext + CHAR_ZERO;
   endfunction

   function automatic logic [RADIX_WIDTH-1:0] clamp_radix(input logic [RADIX_WIDTH-1:0] r);
      if (r < RADIX_MIN) begin
         return RADIX_MIN;
      end
      if (r > RADIX_MAX) begin
         return RADIX_MAX;
      end
      return r;
   endfunction

endpackage

@@ design/integer_to_ascii_radix_top.sv @@
// Top level of the integer-to-ASCII radix converter: control, radix register, output.
// Depends on itar_pkg, itar_divider and itar_digit_stack.

// Converts one VALUE_BITS-bit integer per request word into a run of ASCII
// characters in the radix held by the csr register (2..36, written values
// outside that range are clamped; reset value 10), most significant first,
// last character flagged by rsp_last. Radix 10 treats the value as signed and
// leads with '-'; every other radix treats it as unsigned. Letters are lower
// case. Each digit comes from a bit-serial divider, and a word has up to
// VALUE_BITS digits (in radix 2). One word is converted at a time; req_ready
// is high only between runs. csr_radix may be written only while no
// conversion is in flight.

module integer_to_ascii_radix_top
   import itar_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_BITS-1:0]  req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CHAR_WIDTH-1:0]  rsp_char_code,
   output logic                   rsp_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [RADIX_WIDTH-1:0] csr_radix
);

   state_type              state_ff, state_in;
   logic [RADIX_WIDTH-1:0] radix_ff, radix_in;
   logic                   neg_ff, neg_in;

   logic                   req_neg;
   logic [VALUE_BITS-1:0]  req_mag;
   logic                   div_start;
   logic [VALUE_BITS-1:0]  div_dividend;
   logic [VALUE_BITS-1:0]  div_quotient;
   div_status_type         div_status;
   logic                   stack_push;
   logic                   stack_pop;
   logic [CHAR_WIDTH-1:0]  stack_char;
   logic                   stack_last;

   assign csr_ready = 1'b1;
   assign radix_in  = (csr_valid && csr_ready) ? clamp_radix(csr_radix) : radix_ff;

   // magnitude in unsigned arithmetic, so the most negative value comes out right
   assign req_neg = (radix_ff == DEC_RADIX) && req_value[VALUE_BITS-1];
   assign req_mag = req_neg ? (~req_value + VALUE_BITS'(1)) : req_value;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done && div_status.quo_zero) begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (rsp_ready) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_ready && stack_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      rsp_char_code = stack_char;
      rsp_last      = 1'b0;
      div_start     = 1'b0;
      div_dividend  = div_quotient;
      stack_push    = 1'b0;
      stack_pop     = 1'b0;
      neg_in        = neg_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            div_dividend = req_mag;
            if (req_valid) begin
               div_start = 1'b1;
               neg_in    = req_neg;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               stack_push = 1'b1;
               // keep dividing until the quotient runs out
               div_start  = !div_status.quo_zero;
            end
         end
         ST_SIGN: begin
            rsp_valid     = 1'b1;
            rsp_char_code = CHAR_MINUS;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            rsp_last  = stack_last;
            stack_pop = rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         radix_ff <= RADIX_RESET;
      end else begin
         state_ff <= state_in;
         radix_ff <= radix_in;
      end
      neg_ff <= neg_in;
   end

   itar_divider #(
      .VALUE_BITS (VALUE_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (radix_ff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   itar_digit_stack #(
      .DEPTH (VALUE_BITS)
   ) u_digit_stack (
      .clock     (clock),
      .reset     (reset),
      .push      (stack_push),
      .push_char (digit_char(div_status.remainder)),
      .pop       (stack_pop),
      .top_char  (stack_char),
      .top_last  (stack_last)
   );

`ifndef ASSERT_OFF
   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> req_ready)
      else $error("converter did not return to idle after the last character");

   a_accept_no_output: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid)
      else $error("output word valid right after a request was taken");

   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_char_code == CHAR_MINUS) ||
                     (rsp_char_code >= CHAR_ZERO && rsp_char_code <= CHAR_NINE) ||
                     (rsp_char_code >= CHAR_LOW_A && rsp_char_code <= CHAR_LOW_Z)))
      else $error("character code outside the digit and sign set");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside the divide state");
`endif

endmodule

@@ design/itar_divider.sv @@
// Bit-serial restoring divider: one quotient bit per cycle, small radix divisor.
// Depends on itar_pkg.

module itar_divider
   import itar_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_BITS-1:0]  dividend,
   input  logic [RADIX_WIDTH-1:0] divisor,
   output logic [VALUE_BITS-1:0]  quotient,
   output div_status_type         status
);

   localparam int CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0]  quo_ff, quo_in;
   logic [RADIX_WIDTH-1:0] rem_ff, rem_in;

   logic [RADIX_WIDTH:0]   rem_shift;
   logic                   fits;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[VALUE_BITS-1]};
      fits      = rem_shift >= {1'b0, divisor};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in = fits ? RADIX_WIDTH'(rem_shift - {1'b0, divisor})
                       : rem_shift[RADIX_WIDTH-1:0];
         quo_in = {quo_ff[VALUE_BITS-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(VALUE_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quotient         = quo_ff;
   assign status.done      = done_ff;
   assign status.quo_zero  = (quo_ff == '0);
   assign status.remainder = rem_ff;

endmodule

@@ design/itar_digit_stack.sv @@
// Shift-register LIFO for character codes: push shifts in at the top, pop shifts down.
// Depends on itar_pkg.

module itar_digit_stack
   import itar_pkg::*;
#(
   parameter int DEPTH = VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [CHAR_WIDTH-1:0] push_char,
   input  logic                  pop,
   output logic [CHAR_WIDTH-1:0] top_char,
   output logic                  top_last
);

   localparam int CW = $clog2(DEPTH + 1);

   logic [CHAR_WIDTH-1:0] entry_ff [DEPTH];
   logic [CHAR_WIDTH-1:0] entry_in [DEPTH];
   logic [CW-1:0]         count_ff, count_in;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         entry_in[i] = entry_ff[i];
      end
      count_in = count_ff;
      if (push) begin
         entry_in[0] = push_char;
         for (int i = 1; i < DEPTH; i++) begin
            entry_in[i] = entry_ff[i-1];
         end
         count_in = count_ff + CW'(1);
      end else if (pop) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            entry_in[i] = entry_ff[i+1];
         end
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      for (int i = 0; i < DEPTH; i++) begin
         entry_ff[i] <= entry_in[i];
      end
   end

   assign top_char = entry_ff[0];
   assign top_last = (count_ff == CW'(1));

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for integer_to_ascii_radix_top: drives integer words,
// predicts each character run in the current radix and checks every output word.
// Depends on itar_pkg and the design sources.

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import itar_pkg::*;

   localparam int VALUE_BITS = VALUE_BITS_DEFAULT;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] code;
      logic                  last;
   } text_char_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [VALUE_BITS-1:0]  req_value;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [CHAR_WIDTH-1:0]  rsp_char_code;
   logic                   rsp_last;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [RADIX_WIDTH-1:0] csr_radix;

   text_char_type          expected_chars[$];
   logic [RADIX_WIDTH-1:0] radix_shadow;
   int unsigned            mismatch_count = 0;
   int unsigned            rsp_hold_cycles = 0;
   bit                     fast_mode = 1'b0;

   integer_to_ascii_radix_top #(
      .VALUE_BITS(VALUE_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_char_code(rsp_char_code),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_radix(csr_radix)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("tb NOT OK");
      $finish;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (fast_mode) return 0;
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 120);
   endfunction

   function automatic logic [VALUE_BITS-1:0] pick_value();
      logic [VALUE_BITS-1:0] v;
      case ($urandom_range(0, 7))
         0, 1, 2: v = $urandom;
         3: v = $urandom_range(0, 100);
         4: v = -$urandom_range(1, 100);
         5: v = (VALUE_BITS'(1) << $urandom_range(0, VALUE_BITS - 1))
                + $urandom_range(0, 2) - 1;
         6: begin
            case ($urandom_range(0, 3))
               0: v = '0;
               1: v = {1'b0, {(VALUE_BITS - 1){1'b1}}};
               2: v = {1'b1, {(VALUE_BITS - 1){1'b0}}};
               default: v = '1;
            endcase
         end
         default: v = $urandom >> $urandom_range(0, VALUE_BITS - 1);
      endcase
      return v;
   endfunction

   // Append one expected character at the tail of the queue.
   task automatic queue_char(input text_char_type c);
      expected_chars.insert(expected_chars.size(), c);
   endtask

   // Build the character run for one word in the current radix.
   task automatic predict_text(input logic [VALUE_BITS-1:0] value);
      logic [VALUE_BITS-1:0] base;
      logic [VALUE_BITS-1:0] mag;
      logic [VALUE_BITS-1:0] rem;
      logic [CHAR_WIDTH-1:0] digits[$];
      logic [CHAR_WIDTH-1:0] code;
      text_char_type         c;
      base = radix_shadow;
      if (radix_shadow < RADIX_MIN) begin
         base = RADIX_MIN;
      end else if (radix_shadow > RADIX_MAX) begin
         base = RADIX_MAX;
      end
      mag = value;
      // Only decimal is signed; negate as unsigned so the most negative word works.
      if (base == DEC_RADIX && value[VALUE_BITS-1]) begin
         mag = -value;
         c.code = CHAR_MINUS;
         c.last = 1'b0;
         queue_char(c);
      end
      do begin
         rem = mag % base;
         mag = mag / base;
         if (rem > LAST_PLAIN_DIGIT) begin
            code = CHAR_WIDTH'(rem - 10) + CHAR_LOW_A;
         end else begin
            code = CHAR_WIDTH'(rem) + CHAR_ZERO;
         end
         digits.push_front(code);
      end while (mag != 0);
      foreach (digits[i]) begin
         c.code = digits[i];
         c.last = (i == digits.size() - 1);
         queue_char(c);
      end
   endtask

   // Leaves valid high at the accepting edge; the next action decides what follows.
   task automatic send_value(input logic [VALUE_BITS-1:0] value);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      predict_text(value);
   endtask

   task automatic wait_text_drained();
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
   endtask

   task automatic write_radix(input logic [RADIX_WIDTH-1:0] radix);
      wait_text_drained();
      csr_valid <= 1'b1;
      csr_radix <= radix;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      radix_shadow = radix;
   endtask

   task automatic test_decimal_at_reset();
      send_value('0);
      send_value(1);
      send_value('1);
      send_value({1'b0, {(VALUE_BITS - 1){1'b1}}});
      send_value({1'b1, {(VALUE_BITS - 1){1'b0}}});
      send_value(9);
      send_value(10);
      send_value(-10);
   endtask

   task automatic test_radix_bounds();
      write_radix(RADIX_MIN);
      send_value('0);
      send_value(1);
      send_value('1);
      send_value({1'b1, {(VALUE_BITS - 1){1'b0}}});
      write_radix(RADIX_MAX);
      send_value(35);
      send_value(36);
      send_value('1);
      send_value({1'b1, {(VALUE_BITS - 1){1'b0}}});
   endtask

   task automatic test_radix_clamping();
      write_radix(6'd0);
      send_value(5);
      write_radix(6'd1);
      send_value('1);
      write_radix(6'd37);
      send_value(35);
      write_radix(6'd63);
      send_value(1295);
      write_radix(6'd16);
      send_value(32'hdeadbeef);
   endtask

   // Stall the output long enough that the converter fills and holds off input.
   task automatic test_output_hold_off();
      write_radix(DEC_RADIX);
      fast_mode = 1'b1;
      rsp_hold_cycles = 800;
      repeat (6) send_value(pick_value());
      fast_mode = 1'b0;
   endtask

   task automatic test_random_radix_phases();
      logic [RADIX_WIDTH-1:0] radix;
      for (int phase = 0; phase < 11; phase++) begin
         case (phase)
            0: radix = RADIX_MIN;
            1: radix = RADIX_MAX;
            2: radix = DEC_RADIX;
            3: radix = 6'd63;
            4: radix = 6'd0;
            default: begin
               if ($urandom_range(0, 3) == 0) begin
                  radix = RADIX_WIDTH'($urandom_range(0, 63));
               end else begin
                  radix = RADIX_WIDTH'($urandom_range(RADIX_MIN, RADIX_MAX));
               end
            end
         endcase
         write_radix(radix);
         fast_mode = (phase == 2 || phase == 6);
         repeat (40) send_value(pick_value());
      end
      fast_mode = 1'b0;
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_value <= '0;
      csr_valid <= 1'b0;
      csr_radix <= '0;
      radix_shadow = RADIX_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_decimal_at_reset();
      test_radix_bounds();
      test_radix_clamping();
      test_output_hold_off();
      test_random_radix_phases();

      wait_text_drained();
      repeat (2 * (VALUE_BITS + 2)) @(posedge clock);
      if (expected_chars.size() != 0) begin
         $error("last: %0d characters never arrived", expected_chars.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   initial begin : rsp_side
      int unsigned run_left;
      bit          ready_mode;
      run_left = 0;
      ready_mode = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles != 0) begin
            rsp_hold_cycles--;
            rsp_ready <= 1'b0;
         end else if (fast_mode) begin
            rsp_ready <= 1'b1;
         end else begin
            if (run_left == 0) begin
               ready_mode = ($urandom_range(0, 2) != 0);
               if (ready_mode) begin
                  run_left = $urandom_range(1, 24);
               end else begin
                  run_left = pick_gap() + 1;
               end
            end
            run_left--;
            rsp_ready <= ready_mode;
         end
      end
   end

   initial begin : char_checker
      text_char_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               $error("char_code: no word expected, got 0x%02h", rsp_char_code);
               mismatch_count++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_char_code !== want.code) begin
                  $error("char_code: expected 0x%02h, got 0x%02h", want.code, rsp_char_code);
                  mismatch_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_last);
                  mismatch_count++;
               end
            end
         end
      end
   end

endmodule
